[design/pps_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; imported by pps_ctrl, pps_datapath and the top level.
package pps_pkg;

    localparam int SLOT_BITS = 4;
    localparam int ARR_BITS  = 16;
    localparam int BURST_BITS = 16;
    localparam int PRIO_BITS = 8;
    localparam int ID_BITS   = 5;
    localparam int CFG_BITS  = 5;
    localparam int SUM_BITS  = 32;
    localparam int COUNT_BITS = 5;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 5'd31;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_STEP,
        S_TAT,
        S_WT,
        S_SUM,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // write the input beat into its slot
        logic step;      // take the winner, decrement its work, advance time
        logic tat;       // form turnaround and bump the completion count
        logic wt;        // form waiting time and add turnaround to its total
        logic sum;       // add waiting time to its total
        logic out_load;  // copy the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fin;       // the current winner is on its last tick of work
    } t_dp_status;

endpackage

[design/preemptive_priority_scheduler.sv]
`timescale 1ns / 1ps
// Top level of the preemptive priority scheduler: controller plus datapath.
// Depends on pps_pkg, pps_ctrl and pps_datapath.
//
//   channel   direction  handshake            payload
//   -------   ---------  -------------------  -------------------------------------
//   request   in         i_valid / o_ready    action, slot, arrival, burst, priority
//   result    out        o_valid / i_ready    ran .. total_waiting (one per request)
//   config    in         i_cfg_we             i_cfg_wdata = process_count
//
// A load beat is accepted, then its result enters the output register.
// A tick beat is accepted, waits in the scan state for the registered selection
// tree, then steps; a completing task adds turnaround, waiting and sum states.
// The output register parts the two sides: the next beat may be accepted while
// a result still waits, but a new result stalls in the done state until it is free.
// Reset (synchronous, active low) clears remaining work, time, count and totals.
module preemptive_priority_scheduler
    import pps_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_BITS-1:0]   i_cfg_wdata,
    // request channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_action,
    input  logic [SLOT_BITS-1:0]  i_slot,
    input  logic [ARR_BITS-1:0]   i_arrival,
    input  logic [BURST_BITS-1:0] i_burst,
    input  logic [PRIO_BITS-1:0]  i_priority_req,
    // result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_ran,
    output logic [ID_BITS-1:0]    o_task_id,
    output logic [TIME_BITS-1:0]  o_time_now,
    output logic                  o_finished,
    output logic [TIME_BITS-1:0]  o_turnaround,
    output logic [TIME_BITS-1:0]  o_waiting,
    output logic                  o_all_done,
    output logic [SUM_BITS-1:0]   o_total_turnaround,
    output logic [SUM_BITS-1:0]   o_total_waiting
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencer: accept, wait out the tree, step, tally on completion, publish.
    pps_ctrl #(
        .MAX_TASKS (MAX_TASKS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_action (i_action),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Tables, winner selection, time and running totals.
    pps_datapath #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_slot             (i_slot),
        .i_arrival          (i_arrival),
        .i_burst            (i_burst),
        .i_priority_req     (i_priority_req),
        .o_ran              (o_ran),
        .o_task_id          (o_task_id),
        .o_time_now         (o_time_now),
        .o_finished         (o_finished),
        .o_turnaround       (o_turnaround),
        .o_waiting          (o_waiting),
        .o_all_done         (o_all_done),
        .o_total_turnaround (o_total_turnaround),
        .o_total_waiting    (o_total_waiting)
    );

endmodule

[design/pps_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine of the preemptive priority scheduler.
// Depends on pps_pkg; drives command strobes into pps_datapath.
module pps_ctrl
    import pps_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_action,
    output logic       o_valid,
    input  logic       i_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam int LEVELS = $clog2(MAX_TASKS);
    localparam int CW     = $clog2(LEVELS + 1);
    localparam logic [CW-1:0] LAST_LEVEL = CW'(LEVELS);

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_out_valid, n_out_valid;
    logic in_fire, out_free;

    assign in_fire  = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_valid) begin
                    n_state = (i_action == ACT_LOAD) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt == LAST_LEVEL) begin
                    n_state = S_STEP;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_STEP: n_state = i_status.fin ? S_TAT : S_DONE;
            S_TAT:  n_state = S_WT;
            S_WT:   n_state = S_SUM;
            S_SUM:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = in_fire && (i_action == ACT_LOAD);
        o_cmd.step     = (r_state == S_SCAN) && (r_cnt == LAST_LEVEL);
        o_cmd.tat      = (r_state == S_TAT);
        o_cmd.wt       = (r_state == S_WT);
        o_cmd.sum      = (r_state == S_SUM);
        o_cmd.out_load = (r_state == S_DONE) && out_free;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

[design/pps_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the preemptive priority scheduler: task tables, registered
// selection tree, time and totals, output register. Depends on pps_pkg.
module pps_datapath
    import pps_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_BITS-1:0]   i_cfg_wdata,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic [SLOT_BITS-1:0]  i_slot,
    input  logic [ARR_BITS-1:0]   i_arrival,
    input  logic [BURST_BITS-1:0] i_burst,
    input  logic [PRIO_BITS-1:0]  i_priority_req,
    output logic                  o_ran,
    output logic [ID_BITS-1:0]    o_task_id,
    output logic [TIME_BITS-1:0]  o_time_now,
    output logic                  o_finished,
    output logic [TIME_BITS-1:0]  o_turnaround,
    output logic [TIME_BITS-1:0]  o_waiting,
    output logic                  o_all_done,
    output logic [SUM_BITS-1:0]   o_total_turnaround,
    output logic [SUM_BITS-1:0]   o_total_waiting
);

    localparam int SW     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int LEAVES = 1 << $clog2(MAX_TASKS);
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef struct packed {
        logic                  valid;
        logic [PRIO_BITS-1:0]  prio;
        logic [ARR_BITS-1:0]   arr;
        logic [BURST_BITS-1:0] burst;
        logic                  last;
        logic [SW-1:0]         idx;
    } t_node;

    // Left child holds the lower slots, so it keeps every full tie.
    function automatic t_node pick(input t_node lo, input t_node hi);
        logic take_hi;
        take_hi = hi.valid && (!lo.valid || (hi.prio < lo.prio) ||
                  ((hi.prio == lo.prio) && (hi.arr < lo.arr)));
        return take_hi ? hi : lo;
    endfunction

    function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                    input logic [TIME_BITS-1:0] b);
        logic [SUM_BITS:0] s;
        s = {1'b0, a} + (SUM_BITS + 1)'(b);
        return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
    endfunction

    logic [ARR_BITS-1:0]   r_arr   [MAX_TASKS];
    logic [BURST_BITS-1:0] r_burst [MAX_TASKS];
    logic [PRIO_BITS-1:0]  r_prio  [MAX_TASKS];
    logic [BURST_BITS-1:0] r_rem   [MAX_TASKS];

    t_node r_node [1:2*LEAVES-1];
    t_node root;

    logic [CFG_BITS-1:0]   r_pc;
    logic [TIME_BITS-1:0]  r_time;
    logic [COUNT_BITS-1:0] r_comp;
    logic [SUM_BITS-1:0]   r_sum_tat, r_sum_wt;

    logic                  r_ran, r_fin;
    logic [ID_BITS-1:0]    r_id;
    logic [TIME_BITS-1:0]  r_tat, r_wt;
    logic [ARR_BITS-1:0]   r_best_arr;
    logic [BURST_BITS-1:0] r_best_burst;
    logic [31:0]           slot_ext;
    logic [31:0]           active;
    logic                  all_done;

    assign root            = r_node[1];
    assign o_status.fin    = root.valid && root.last;
    assign slot_ext        = 32'(i_slot);
    assign active          = (32'(r_pc) > 32'(MAX_TASKS)) ? 32'(MAX_TASKS) : 32'(r_pc);
    assign all_done        = 32'(r_comp) >= active;

    // Task tables: load writes a whole slot, a step takes one tick of work.
    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_slot
        always_ff @(posedge i_clk) begin
            if (i_cmd.load && (slot_ext == 32'(g))) begin
                r_arr[g]   <= i_arrival;
                r_burst[g] <= i_burst;
                r_prio[g]  <= i_priority_req;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rem[g] <= '0;
            end else if (i_cmd.load && (slot_ext == 32'(g))) begin
                r_rem[g] <= i_burst;
            end else if (i_cmd.step && root.valid && (root.idx == SW'(g))) begin
                r_rem[g] <= r_rem[g] - BURST_BITS'(1);
            end
        end
    end

    // Leaves: eligibility of each slot, sampled every cycle.
    for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
        if (g < MAX_TASKS) begin : g_real
            always_ff @(posedge i_clk) begin
                r_node[LEAVES+g].valid <= (r_rem[g] != '0) &&
                                          (TIME_BITS'(r_arr[g]) <= r_time) &&
                                          (32'(g) < 32'(r_pc));
                r_node[LEAVES+g].prio  <= r_prio[g];
                r_node[LEAVES+g].arr   <= r_arr[g];
                r_node[LEAVES+g].burst <= r_burst[g];
                r_node[LEAVES+g].last  <= (r_rem[g] == BURST_BITS'(1));
                r_node[LEAVES+g].idx   <= SW'(g);
            end
        end else begin : g_pad
            always_ff @(posedge i_clk) begin
                r_node[LEAVES+g] <= '0;
            end
        end
    end

    // Inner nodes: one registered compare level per tree level.
    for (genvar n = 1; n < LEAVES; n++) begin : g_inner
        always_ff @(posedge i_clk) begin
            r_node[n] <= pick(r_node[2*n], r_node[2*n+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= '0;
            r_time    <= '0;
            r_comp    <= '0;
            r_sum_tat <= '0;
            r_sum_wt  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_pc <= i_cfg_wdata;
            end
            if (i_cmd.step && (r_time != TIME_MAX)) begin
                r_time <= r_time + TIME_BITS'(1);
            end
            if (i_cmd.tat && (r_comp != COUNT_MAX)) begin
                r_comp <= r_comp + COUNT_BITS'(1);
            end
            if (i_cmd.wt) begin
                r_sum_tat <= sat_add(r_sum_tat, r_tat);
            end
            if (i_cmd.sum) begin
                r_sum_wt <= sat_add(r_sum_wt, r_wt);
            end
        end
    end

    // Per-item working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ran <= 1'b0;
            r_id  <= '0;
            r_fin <= 1'b0;
            r_tat <= '0;
            r_wt  <= '0;
        end
        if (i_cmd.step) begin
            r_ran        <= root.valid;
            r_id         <= root.valid ? ID_BITS'(32'(root.idx) + 32'd1) : '0;
            r_fin        <= root.valid && root.last;
            r_best_arr   <= root.arr;
            r_best_burst <= root.burst;
            r_tat        <= '0;
            r_wt         <= '0;
        end
        if (i_cmd.tat) begin
            r_tat <= r_time - TIME_BITS'(r_best_arr);
        end
        if (i_cmd.wt) begin
            r_wt <= (r_tat >= TIME_BITS'(r_best_burst)) ?
                    r_tat - TIME_BITS'(r_best_burst) : '0;
        end
    end

    // Output register: holds the result beat until it is taken.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_ran              <= r_ran;
            o_task_id          <= r_id;
            o_time_now         <= r_time;
            o_finished         <= r_fin;
            o_turnaround       <= r_tat;
            o_waiting          <= r_wt;
            o_all_done         <= all_done;
            o_total_turnaround <= r_sum_tat;
            o_total_waiting    <= r_sum_wt;
        end
    end

endmodule
